// ===== rtl/assert_macros.svh =====
// assertion macros shared by the letter bigram sampler rtl
// no dependencies; included by the controller and the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/lbms_pkg.sv =====
// shared types and constants of the letter bigram sampler
// no dependencies; used by lbms_ctrl, lbms_datapath and the top level
package lbms_pkg;

  // default configuration
  localparam int unsigned DEF_ALPHABET      = 26;
  localparam int unsigned DEF_COUNT_BITS    = 16;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // fixed field widths
  localparam int unsigned TRAIN_BYTE_W = 8;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned FRAC_IN_W    = 16;

  // ascii code of the first letter
  localparam int unsigned LETTER_BASE = 97;

  // request codes
  localparam logic REQ_TRAIN  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic train_rd;
    logic train_wr;
    logic mul;
    logic walk;
  } lbms_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic walk_end;
  } lbms_sts_t;

endpackage

// ===== rtl/lbms_ctrl.sv =====
// controller state machine of the letter bigram sampler
// depends on lbms_pkg and assert_macros.svh
`include "assert_macros.svh"

module lbms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                req_type_i,
  output logic                busy_o,
  output logic                done_o,
  output lbms_pkg::lbms_cmd_t cmd_o,
  input  lbms_pkg::lbms_sts_t sts_i
);
  import lbms_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRAIN_RD,
    ST_TRAIN_WR,
    ST_MUL,
    ST_WALK
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // state, busy and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            busy_q  <= 1'b1;
            state_q <= (req_type_i == REQ_SAMPLE) ? ST_MUL : ST_TRAIN_RD;
          end
        end
        ST_TRAIN_RD: begin
          state_q <= ST_TRAIN_WR;
        end
        ST_TRAIN_WR: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        ST_MUL: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (sts_i.walk_end) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.clear_wr = (state_q == ST_CLEAR);
    cmd_o.load     = (state_q == ST_IDLE) && start_i;
    cmd_o.train_rd = (state_q == ST_TRAIN_RD);
    cmd_o.train_wr = (state_q == ST_TRAIN_WR);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.walk     = (state_q == ST_WALK);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  // a result strobe always comes with the block ready again
  `ASSERT_PROP(a_done_not_busy, clk_i, rst_ni, done_q |-> !busy_q, "result while busy")
  // a result strobe lasts a single cycle
  `ASSERT_PROP(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "result strobe too long")
  // a train word keeps the block busy through the read and write states, then frees it
  `ASSERT_PROP(a_train_len, clk_i, rst_ni,
    (start_i && !busy_q && req_type_i == REQ_TRAIN) |=> busy_q ##1 busy_q ##1 !busy_q,
    "train word took the wrong number of cycles")

endmodule

// ===== rtl/lbms_datapath.sv =====
// datapath of the letter bigram sampler: pair count memory, row sums, sample walk
// depends on lbms_pkg and assert_macros.svh
`include "assert_macros.svh"

module lbms_datapath #(
  parameter int unsigned ALPHABET      = lbms_pkg::DEF_ALPHABET,
  parameter int unsigned COUNT_BITS    = lbms_pkg::DEF_COUNT_BITS,
  parameter int unsigned FRACTION_BITS = lbms_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lbms_pkg::lbms_cmd_t              cmd_i,
  output lbms_pkg::lbms_sts_t              sts_o,
  input  logic [lbms_pkg::TRAIN_BYTE_W-1:0] train_byte_i,
  input  logic [lbms_pkg::LETTER_W-1:0]     current_letter_i,
  input  logic [lbms_pkg::FRAC_IN_W-1:0]    random_fraction_i,
  output logic [lbms_pkg::LETTER_W-1:0]     next_letter_o
);
  import lbms_pkg::*;

  localparam int unsigned LW    = $clog2(ALPHABET);
  localparam int unsigned DEPTH = ALPHABET * ALPHABET;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = COUNT_BITS + $clog2(ALPHABET);
  localparam int unsigned PW    = FRACTION_BITS + RW;

  // pair count memory
  logic [COUNT_BITS-1:0]    mem_q [DEPTH];
  logic [COUNT_BITS-1:0]    rdata_q;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [COUNT_BITS-1:0]    wr_data;

  // row sums
  logic [RW-1:0]            rt_q [ALPHABET];
  logic [LW-1:0]            rt_idx;
  logic [RW-1:0]            rt_rd;

  // request and walk registers
  logic [TRAIN_BYTE_W-1:0]  byte_q;
  logic [LW-1:0]            row_q;
  logic [LW-1:0]            row_sel;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [AW-1:0]            base_q;
  logic [LW-1:0]            col_q;
  logic [RW-1:0]            cum_q;
  logic [RW-1:0]            cum_nxt;
  logic [PW-1:0]            prod_q;
  logic [LW-1:0]            pick_q;
  logic [LW-1:0]            prev_q;
  logic                     prev_vld_q;
  logic [AW-1:0]            clr_q;

  logic                     is_letter;
  logic [LW-1:0]            cur_letter;
  logic [AW-1:0]            train_addr;
  logic                     bump;
  logic                     last_col;
  logic                     hit;

  // training byte decode
  assign is_letter  = (32'(byte_q) >= LETTER_BASE) && (32'(byte_q) < LETTER_BASE + ALPHABET);
  assign cur_letter = LW'(byte_q - TRAIN_BYTE_W'(LETTER_BASE));
  assign train_addr = AW'(32'(prev_q) * ALPHABET + 32'(cur_letter));
  assign bump       = cmd_i.train_wr && is_letter && prev_vld_q && !(&rdata_q);

  // out of range rows sample the last row
  assign row_sel = (32'(current_letter_i) >= ALPHABET) ? LW'(ALPHABET - 1)
                                                      : LW'(current_letter_i);

  // memory read port
  assign last_col = (col_q == LW'(ALPHABET - 1));
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd_i.train_rd) begin
      rd_en   = 1'b1;
      rd_addr = train_addr;
    end else if (cmd_i.mul) begin
      rd_en   = 1'b1;
      rd_addr = base_q;
    end else if (cmd_i.walk && !last_col) begin
      rd_en   = 1'b1;
      rd_addr = AW'(32'(base_q) + 32'(col_q) + 32'd1);
    end
  end

  // memory write port: clearing pass or count increment
  assign wr_en   = cmd_i.clear_wr || bump;
  assign wr_addr = cmd_i.clear_wr ? clr_q : train_addr;
  assign wr_data = cmd_i.clear_wr ? COUNT_BITS'(1) : rdata_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // row sums, one read address shared by sampling and training
  assign rt_idx = cmd_i.mul ? row_q : prev_q;
  assign rt_rd  = rt_q[rt_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        rt_q[i] <= RW'(ALPHABET);
      end
    end else if (bump) begin
      rt_q[prev_q] <= rt_rd + RW'(1);
    end
  end

  // previous letter tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
    end else if (cmd_i.train_wr) begin
      if (is_letter) begin
        prev_q     <= cur_letter;
        prev_vld_q <= 1'b1;
      end else begin
        prev_vld_q <= 1'b0;
      end
    end
  end

  // cumulative walk compare
  assign cum_nxt = cum_q + RW'(rdata_q);
  assign hit     = prod_q < {cum_nxt, {FRACTION_BITS{1'b0}}};

  // request capture, scaled fraction and walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= train_byte_i;
      row_q  <= row_sel;
      frac_q <= FRACTION_BITS'(random_fraction_i);
      base_q <= AW'(32'(row_sel) * ALPHABET);
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(frac_q) * PW'(rt_rd);
      cum_q  <= '0;
      col_q  <= '0;
    end
    if (cmd_i.walk) begin
      if (hit || last_col) begin
        pick_q <= col_q;
      end else begin
        cum_q <= cum_nxt;
        col_q <= col_q + LW'(1);
      end
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.walk_end   = hit || last_col;
  assign next_letter_o    = LETTER_W'(pick_q);

  // every row sum covers at least one count per letter
  `ASSERT_NEVER(a_row_sum_min, clk_i, rst_ni, cmd_i.mul && (rt_rd < RW'(ALPHABET)),
    "row sum below alphabet size")

endmodule

// ===== rtl/letter_bigram_markov_sampler.sv =====
// top level of the letter bigram sampler
// depends on lbms_pkg, lbms_ctrl and lbms_datapath
//
// Command interface: a word is taken at a rising edge with start high and busy
// low. req_type_i selects training (train_byte_i) or sampling (current_letter_i,
// random_fraction_i). Sampling returns next_letter_o, shown for one cycle with
// done_o high; the receiver cannot hold it off. Training returns nothing.
// Training is a read-modify-write of the pair count memory: after the accepting
// edge, busy stays high through a read state and a write state.
// Sampling multiplies the fraction by the row sum, then walks the row one
// stored count per cycle through the single memory read port; done_o goes high
// as the walk stops at the picked letter, or at the last letter, so a sample
// word lasts longer the later the letter that is picked.
// busy falls with done_o, so the next word can be taken in the result cycle.
// After reset the block sweeps all ALPHABET * ALPHABET entries of the count
// memory (676 by default) to 1, one entry a cycle, with busy high.
module letter_bigram_markov_sampler #(
  parameter int unsigned ALPHABET      = lbms_pkg::DEF_ALPHABET,
  parameter int unsigned COUNT_BITS    = lbms_pkg::DEF_COUNT_BITS,
  parameter int unsigned FRACTION_BITS = lbms_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type_i,
  input  logic [lbms_pkg::TRAIN_BYTE_W-1:0] train_byte_i,
  input  logic [lbms_pkg::LETTER_W-1:0]     current_letter_i,
  input  logic [lbms_pkg::FRAC_IN_W-1:0]    random_fraction_i,
  output logic                              done_o,
  output logic [lbms_pkg::LETTER_W-1:0]     next_letter_o
);
  import lbms_pkg::*;

  lbms_cmd_t cmd;
  lbms_sts_t sts;

  // sequencing
  lbms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .busy_o     (busy),
    .done_o     (done_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // storage and arithmetic
  lbms_datapath #(
    .ALPHABET      (ALPHABET),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .train_byte_i      (train_byte_i),
    .current_letter_i  (current_letter_i),
    .random_fraction_i (random_fraction_i),
    .next_letter_o     (next_letter_o)
  );

endmodule

// ===== test/letter_bigram_markov_sampler_tb.sv =====
// self-checking testbench for the letter bigram sampler: training and sampling words
// depends on lbms_pkg and letter_bigram_markov_sampler; uses its own model of the count table
module letter_bigram_markov_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbms_pkg::*;

  localparam int unsigned NUM_LETTERS  = DEF_ALPHABET;
  localparam int unsigned NUM_PAIRS    = NUM_LETTERS * NUM_LETTERS;
  localparam int unsigned COUNT_TOP    = (1 << DEF_COUNT_BITS) - 1;
  localparam int unsigned SUM_W        = 21;
  localparam int          RANDOM_WORDS = 1250;
  localparam int          PILE_WORDS   = 100;
  localparam int          MAX_GAP      = 8;
  localparam longint      CYCLE_LIMIT  = 250_000;

  // one row of the directed plan; want is used only when known is set
  typedef struct {
    logic                    req;
    logic [TRAIN_BYTE_W-1:0] text;
    logic [LETTER_W-1:0]     row;
    logic [FRAC_IN_W-1:0]    frac;
    bit                      known;
    logic [LETTER_W-1:0]     want;
  } plan_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    req_type_i;
  logic [TRAIN_BYTE_W-1:0] train_byte_i;
  logic [LETTER_W-1:0]     current_letter_i;
  logic [FRAC_IN_W-1:0]    random_fraction_i;
  logic                    done_o;
  logic [LETTER_W-1:0]     next_letter_o;

  // model of the count table and the word tracker
  logic [DEF_COUNT_BITS-1:0] pair_count [NUM_PAIRS];
  logic [SUM_W-1:0]          row_sum [NUM_LETTERS];
  logic [LETTER_W-1:0]       prev_letter;
  bit                        prev_ok;

  logic [LETTER_W-1:0] pending_letters [$];
  int                  errors = 0;
  longint              cycle_count = 0;
  plan_row_t           plan [$];

  letter_bigram_markov_sampler u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .train_byte_i     (train_byte_i),
    .current_letter_i (current_letter_i),
    .random_fraction_i(random_fraction_i),
    .done_o           (done_o),
    .next_letter_o    (next_letter_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle counter and watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("letter_bigram_markov_sampler: mismatch");
    $finish;
  end

  // table back to its reset contents
  function automatic void clear_table();
    for (int i = 0; i < NUM_PAIRS; i++) pair_count[i] = DEF_COUNT_BITS'(1);
    for (int i = 0; i < NUM_LETTERS; i++) row_sum[i] = SUM_W'(NUM_LETTERS);
    prev_letter = '0;
    prev_ok     = 1'b0;
  endfunction

  // a training byte: count the pair if both bytes are letters, else end the word
  function automatic void learn_byte(logic [TRAIN_BYTE_W-1:0] b);
    int unsigned cur;
    int unsigned idx;
    if (b >= LETTER_BASE && b < LETTER_BASE + NUM_LETTERS) begin
      cur = b - LETTER_BASE;
      if (prev_ok) begin
        idx = prev_letter * NUM_LETTERS + cur;
        // saturated counts stay put, and so does the row sum
        if (pair_count[idx] != COUNT_TOP) begin
          pair_count[idx]   = pair_count[idx] + 1'b1;
          row_sum[prev_letter] = row_sum[prev_letter] + 1'b1;
        end
      end
      prev_letter = LETTER_W'(cur);
      prev_ok     = 1'b1;
    end else begin
      prev_ok = 1'b0;
    end
  endfunction

  // first letter whose running count, scaled by 2^16, exceeds frac * row sum
  function automatic logic [LETTER_W-1:0] pick_next(logic [LETTER_W-1:0] letter,
                                                    logic [FRAC_IN_W-1:0] frac);
    int unsigned         r;
    longint unsigned     product;
    longint unsigned     cum;
    logic [LETTER_W-1:0] pick;
    // rows past the alphabet fall back to the last one
    r       = (letter >= NUM_LETTERS) ? NUM_LETTERS - 1 : letter;
    product = 64'(frac) * 64'(row_sum[r]);
    cum     = 0;
    pick    = LETTER_W'(NUM_LETTERS - 1);
    for (int j = 0; j < NUM_LETTERS; j++) begin
      cum = cum + 64'(pair_count[r * NUM_LETTERS + j]);
      if (product < (cum << DEF_FRACTION_BITS)) begin
        pick = LETTER_W'(j);
        break;
      end
    end
    return pick;
  endfunction

  // hand one word to the block; returns right after the accepting edge
  task automatic send_word(input logic req, input logic [TRAIN_BYTE_W-1:0] text,
                           input logic [LETTER_W-1:0] row,
                           input logic [FRAC_IN_W-1:0] frac, input int gap,
                           input bit known, input logic [LETTER_W-1:0] want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    req_type_i        <= req;
    train_byte_i      <= text;
    current_letter_i  <= row;
    random_fraction_i <= frac;
    // busy is sampled mid-cycle; low there means the next edge takes the word
    do @(negedge clk_i); while (busy !== 1'b0);
    @(posedge clk_i);
    if (req == REQ_SAMPLE) begin
      pending_letters.push_back(known ? want : pick_next(row, frac));
    end else begin
      learn_byte(text);
    end
  endtask

  // drop start so the last word is not taken again, then wait for every result
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_letters.size() != 0) @(posedge clk_i);
  endtask

  // result checker: a result is checked mid-cycle, at the falling edge
  always @(negedge clk_i) begin
    logic [LETTER_W-1:0] want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_letters.size() == 0) begin
        $error("next_letter: expected none, actual %0d", next_letter_o);
        errors++;
      end else begin
        want = pending_letters.pop_front();
        if (next_letter_o !== want) begin
          $error("next_letter: expected %0d, actual %0d", want, next_letter_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int  gap;
    bit  burst;
    logic                    req;
    logic [TRAIN_BYTE_W-1:0] text;
    logic [LETTER_W-1:0]     row;
    logic [FRAC_IN_W-1:0]    frac;

    rst_ni            <= 1'b0;
    start             <= 1'b0;
    req_type_i        <= REQ_TRAIN;
    train_byte_i      <= '0;
    current_letter_i  <= '0;
    random_fraction_i <= '0;
    clear_table();

    // directed plan: fresh-table samples first, then word boundaries and pairs, then samples
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd0,  16'd0,     1'b1, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd25, 16'd65535, 1'b1, 5'd25});
    plan.push_back('{REQ_SAMPLE, 8'd255, 5'd31, 16'd65535, 1'b1, 5'd25});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd12, 16'd32768, 1'b1, 5'd13});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd26, 16'd0,     1'b1, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd7,  16'd1,     1'b1, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd122, 5'd31, 16'hffff,  1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd97,  5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd97,  5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd96,  5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd123, 5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd98,  5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd99,  5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd0,   5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd255, 5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd113, 5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_TRAIN,  8'd122, 5'd0,  16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd25, 16'd0,     1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd25, 16'd65535, 1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd1,  16'd20000, 1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd16, 16'd65535, 1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd31, 16'd2600,  1'b0, 5'd0});
    plan.push_back('{REQ_SAMPLE, 8'd0,   5'd0,  16'd3000,  1'b0, 5'd0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words, gaps drawn per word
    foreach (plan[i]) begin
      send_word(plan[i].req, plan[i].text, plan[i].row, plan[i].frac,
                $urandom_range(0, MAX_GAP), plan[i].known, plan[i].want);
    end

    // hold off until the block has answered everything
    wait_for_results();

    // pile counts onto the a-a pair, then sample the lopsided row and the b row
    send_word(REQ_TRAIN, 8'd32, 5'd0, 16'd0, 1, 1'b0, 5'd0);
    for (int i = 0; i < PILE_WORDS; i++) begin
      send_word(REQ_TRAIN, TRAIN_BYTE_W'(LETTER_BASE), 5'd0, 16'd0, 0, 1'b0, 5'd0);
    end
    foreach (plan[i]) begin
      frac = (i % 4 == 0) ? 16'd65535 : (i % 4 == 1) ? 16'd65513 :
             (i % 4 == 2) ? FRAC_IN_W'(16'd65520 - i) :
                            FRAC_IN_W'($urandom_range(0, 65535));
      send_word(REQ_SAMPLE, 8'd0, (i % 3 == 0) ? 5'd0 : 5'd1, frac,
                $urandom_range(0, 2), 1'b0, 5'd0);
    end

    // random traffic: mostly letter runs broken by other bytes, plus samples
    burst = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) == 0) wait_for_results();
      gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
      text = TRAIN_BYTE_W'($urandom_range(0, 255));
      row  = LETTER_W'($urandom_range(0, 31));
      frac = FRAC_IN_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 4) begin
        req = REQ_SAMPLE;
        if ($urandom_range(0, 7) != 0) row = LETTER_W'($urandom_range(0, NUM_LETTERS - 1));
      end else begin
        req = REQ_TRAIN;
        if ($urandom_range(0, 4) != 0) begin
          text = TRAIN_BYTE_W'(LETTER_BASE + $urandom_range(0, NUM_LETTERS - 1));
        end
      end
      send_word(req, text, row, frac, gap, 1'b0, 5'd0);
    end

    // drain and let the last walk settle
    wait_for_results();
    repeat (NUM_LETTERS + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("letter_bigram_markov_sampler: match");
    end else begin
      $display("letter_bigram_markov_sampler: mismatch");
    end
    $finish;
  end

endmodule
